/* rtl/scpf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpf_pkg
// Shared constants, codes and controller/datapath interface types of the
// scanline polygon span fill unit.
// ----------------------------------------------------------------------------
package scpf_pkg;

  localparam int MAX_EDGES     = 32;
  localparam int NUM_SCANLINES = 1024;
  localparam int FRAC_BITS     = 16;
  localparam int MAX_SPANS     = 16;

  localparam int COORD_W    = 10;
  localparam int LINE_W     = COORD_W + 1;
  localparam int X_BITS     = 11 + FRAC_BITS;
  localparam int QN_W       = COORD_W + FRAC_BITS;
  localparam int EDGE_IDX_W = $clog2(MAX_EDGES);
  localparam int CNT_W      = EDGE_IDX_W + 1;
  localparam int SPAN_W     = $clog2(MAX_SPANS);
  localparam int DIV_CNT_W  = $clog2(QN_W);

  // input command codes
  typedef enum logic [1:0] {
    CMD_VERTEX = 2'd0,
    CMD_CLOSE  = 2'd1,
    CMD_FILL   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // kind of result the datapath places on the output
  typedef enum logic [1:0] {
    EMIT_ACK  = 2'd0,
    EMIT_PAST = 2'd1,
    EMIT_SPAN = 2'd2
  } emit_t;

  // edge endpoint selection
  typedef enum logic {
    SEL_PREV_TO_NEW   = 1'b0,
    SEL_NEW_TO_FIRST  = 1'b1
  } edge_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic      latch;
    logic      clear;
    edge_sel_t edge_sel;
    logic      set_full;
    logic      div_start;
    logic      edge_write;
    logic      vtx_update;
    logic      scan_step;
    logic      line_adv;
    logic      emit;
    emit_t     emit_kind;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic vertex_seen;
    logic close_cmd;
    logic horiz;
    logic full;
    logic div_busy;
    logic past_top;
    logic no_edges;
    logic scan_last;
    logic emit_last;
  } dp_stat_t;

endpackage

/* rtl/scpf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpf_div
// Restoring divider for the inverse slope: (dx << FRAC_BITS) / dy, truncated
// toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scpf_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [scpf_pkg::COORD_W:0]   num_dx,
  input  logic signed [scpf_pkg::COORD_W:0]   den_dy,
  output logic                                busy,
  output logic        [scpf_pkg::X_BITS-1:0]  quotient
);

  logic                               busy_r;
  logic [scpf_pkg::DIV_CNT_W-1:0]     cnt;
  logic [scpf_pkg::COORD_W:0]         rem;
  logic [scpf_pkg::QN_W-1:0]          q;
  logic [scpf_pkg::COORD_W-1:0]       den;
  logic                               neg;

  logic [scpf_pkg::COORD_W:0]         mag_dx;
  logic [scpf_pkg::COORD_W:0]         mag_dy;
  logic [scpf_pkg::COORD_W:0]         rem_sh;
  logic                               ge;
  logic [scpf_pkg::X_BITS-1:0]        q_ext;

  // operand magnitudes
  assign mag_dx = num_dx[scpf_pkg::COORD_W] ? -num_dx : num_dx;
  assign mag_dy = den_dy[scpf_pkg::COORD_W] ? -den_dy : den_dy;

  // one restoring step
  assign rem_sh = {rem[scpf_pkg::COORD_W-1:0], q[scpf_pkg::QN_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  assign q_ext    = {1'b0, q};
  assign quotient = neg ? -q_ext : q_ext;
  assign busy     = busy_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_r <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt    <= scpf_pkg::DIV_CNT_W'(scpf_pkg::QN_W - 1);
    end else if (busy_r) begin
      if (cnt == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= {mag_dx[scpf_pkg::COORD_W-1:0], {scpf_pkg::FRAC_BITS{1'b0}}};
      den <= mag_dy[scpf_pkg::COORD_W-1:0];
      rem <= '0;
      neg <= num_dx[scpf_pkg::COORD_W] ^ den_dy[scpf_pkg::COORD_W];
    end else if (busy_r) begin
      rem <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
      q   <= {q[scpf_pkg::QN_W-2:0], ge};
    end
  end

endmodule

/* rtl/scpf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpf_datapath
// Edge store, vertex state, active edge sort row, span emitter and result
// registers of the scanline polygon span fill unit.
// ----------------------------------------------------------------------------
module scpf_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  scpf_pkg::dp_cmd_t                  cmd,
  output scpf_pkg::dp_stat_t                 stat,
  input  logic [1:0]                         command,
  input  logic [scpf_pkg::COORD_W-1:0]       vertex_x,
  input  logic [scpf_pkg::COORD_W-1:0]       vertex_y,
  output logic                               result_valid,
  output logic [scpf_pkg::COORD_W-1:0]       scanline,
  output logic [scpf_pkg::COORD_W-1:0]       span_start,
  output logic [scpf_pkg::COORD_W-1:0]       span_end,
  output logic                               span_valid,
  output logic                               last,
  output logic                               fill_done,
  output logic                               table_full
);

  localparam int CW = scpf_pkg::COORD_W;
  localparam int XB = scpf_pkg::X_BITS;
  localparam int NE = scpf_pkg::MAX_EDGES;

  // edge store
  logic [CW-1:0] edge_low_y  [NE];
  logic [CW-1:0] edge_high_y [NE];
  logic [XB-1:0] edge_cur_x  [NE];
  logic [XB-1:0] edge_step   [NE];
  logic [NE-1:0] edge_active;
  logic [scpf_pkg::CNT_W-1:0] edge_count;

  // vertex state
  logic [CW-1:0] first_x, first_y, prev_x, prev_y;
  logic          vertex_seen;
  logic [scpf_pkg::LINE_W-1:0] top_y, current_line;

  // latched item
  logic [1:0]    cmd_r;
  logic [CW-1:0] vx_r, vy_r;
  logic [CW-1:0] line_r;
  logic          full_flag;

  // sort row and scan
  logic signed [XB-1:0] key [NE];
  logic [scpf_pkg::CNT_W-1:0]      n_act;
  logic [scpf_pkg::EDGE_IDX_W-1:0] scan_idx;
  logic [scpf_pkg::SPAN_W-1:0]     span_k;

  // edge endpoints
  logic [CW-1:0] ax, ay, bx, by;
  logic signed [CW:0] dx, dy;
  logic [XB-1:0] div_q;
  logic          div_busy;

  scpf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num_dx   (dx),
    .den_dy   (dy),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // endpoint selection for the edge being stored
  always_comb begin
    unique case (cmd.edge_sel)
      scpf_pkg::SEL_PREV_TO_NEW: begin
        ax = prev_x; ay = prev_y; bx = vx_r; by = vy_r;
      end
      default: begin
        ax = vx_r; ay = vy_r; bx = first_x; by = first_y;
      end
    endcase
  end

  assign dx = $signed({1'b0, bx}) - $signed({1'b0, ax});
  assign dy = $signed({1'b0, by}) - $signed({1'b0, ay});

  // scan step: activation, retirement and insertion of the current edge
  logic act_new;
  logic signed [XB-1:0] ins_x;
  logic [NE-1:0] ge_pos;

  assign act_new = ((edge_low_y[scan_idx] == line_r) || edge_active[scan_idx])
                   && (edge_high_y[scan_idx] != line_r);
  assign ins_x   = $signed(edge_cur_x[scan_idx]);

  always_comb begin
    for (int j = 0; j < NE; j++) begin
      ge_pos[j] = (scpf_pkg::CNT_W'(j) >= n_act) || (key[j] > ins_x);
    end
  end

  // span emitter
  logic [scpf_pkg::EDGE_IDX_W-1:0] pair_lo, pair_hi;
  logic [scpf_pkg::CNT_W:0]        pair_next_end;
  logic                            few_edges, span_last;
  logic [CW-1:0]                   pix_lo, pix_hi;
  logic signed [XB-1:0]            x_lo, x_hi;

  assign pair_lo       = scpf_pkg::EDGE_IDX_W'({span_k, 1'b0});
  assign pair_hi       = scpf_pkg::EDGE_IDX_W'({span_k, 1'b1});
  assign pair_next_end = (scpf_pkg::CNT_W + 1)'({span_k, 1'b0})
                         + (scpf_pkg::CNT_W + 1)'(3);
  assign few_edges     = n_act < scpf_pkg::CNT_W'(2);
  assign span_last     = (span_k == scpf_pkg::SPAN_W'(scpf_pkg::MAX_SPANS - 1))
                         || (pair_next_end >= {1'b0, n_act});
  assign x_lo   = key[pair_lo];
  assign x_hi   = key[pair_hi];
  // truncate to pixel: negative gives 0, integer part is at most 1023
  assign pix_lo = x_lo[XB-1] ? '0 : x_lo[XB-2:scpf_pkg::FRAC_BITS];
  assign pix_hi = x_hi[XB-1] ? '0 : x_hi[XB-2:scpf_pkg::FRAC_BITS];

  // status
  assign stat.vertex_seen = vertex_seen;
  assign stat.close_cmd   = (cmd_r == scpf_pkg::CMD_CLOSE);
  assign stat.horiz       = (ay == by);
  assign stat.full        = edge_count >= scpf_pkg::CNT_W'(NE);
  assign stat.div_busy    = div_busy;
  assign stat.past_top    = (current_line >= top_y)
                            || (current_line >= scpf_pkg::LINE_W'(scpf_pkg::NUM_SCANLINES));
  assign stat.no_edges    = (edge_count == '0);
  assign stat.scan_last   = ({1'b0, scan_idx} == edge_count - 1'b1);
  assign stat.emit_last   = few_edges || span_last;

  // control registers
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      edge_count   <= '0;
      edge_active  <= '0;
      vertex_seen  <= 1'b0;
      first_x      <= '0;
      first_y      <= '0;
      prev_x       <= '0;
      prev_y       <= '0;
      top_y        <= '0;
      current_line <= '0;
    end else begin
      if (cmd.edge_write) begin
        edge_count <= edge_count + 1'b1;
        edge_active[edge_count[scpf_pkg::EDGE_IDX_W-1:0]] <= 1'b0;
      end
      if (cmd.vtx_update) begin
        if (!vertex_seen) begin
          first_x <= vx_r;
          first_y <= vy_r;
        end
        prev_x      <= vx_r;
        prev_y      <= vy_r;
        vertex_seen <= !(cmd_r == scpf_pkg::CMD_CLOSE);
        if ({1'b0, vy_r} > top_y) begin
          top_y <= {1'b0, vy_r};
        end
      end
      if (cmd.scan_step) begin
        edge_active[scan_idx] <= act_new;
      end
      if (cmd.line_adv) begin
        current_line <= current_line + 1'b1;
      end
    end
  end

  // item latch, scan counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      n_act     <= '0;
      scan_idx  <= '0;
      span_k    <= '0;
      full_flag <= 1'b0;
    end else if (cmd.latch) begin
      n_act     <= '0;
      scan_idx  <= '0;
      span_k    <= '0;
      full_flag <= 1'b0;
    end else begin
      if (cmd.set_full) begin
        full_flag <= 1'b1;
      end
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + 1'b1;
        if (act_new) begin
          n_act <= n_act + 1'b1;
        end
      end
      if (cmd.emit && cmd.emit_kind == scpf_pkg::EMIT_SPAN) begin
        span_k <= span_k + 1'b1;
      end
    end
  end

  // latched item fields
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r  <= command;
      vx_r   <= vertex_x;
      vy_r   <= vertex_y;
      line_r <= current_line[CW-1:0];
    end
  end

  // edge store writes
  always_ff @(posedge clk) begin
    if (cmd.edge_write) begin
      edge_low_y[edge_count[scpf_pkg::EDGE_IDX_W-1:0]]  <= (ay < by) ? ay : by;
      edge_high_y[edge_count[scpf_pkg::EDGE_IDX_W-1:0]] <= (ay < by) ? by : ay;
      edge_cur_x[edge_count[scpf_pkg::EDGE_IDX_W-1:0]]  <=
        {1'b0, ((ay < by) ? ax : bx), {scpf_pkg::FRAC_BITS{1'b0}}};
      edge_step[edge_count[scpf_pkg::EDGE_IDX_W-1:0]]   <= div_q;
    end else if (cmd.scan_step && act_new) begin
      edge_cur_x[scan_idx] <= edge_cur_x[scan_idx] + edge_step[scan_idx];
    end
  end

  // sorted insertion row
  always_ff @(posedge clk) begin
    if (cmd.scan_step && act_new) begin
      for (int j = 0; j < NE; j++) begin
        if (ge_pos[j]) begin
          if (j == 0) begin
            key[j] <= ins_x;
          end else if (!ge_pos[j-1]) begin
            key[j] <= ins_x;
          end else begin
            key[j] <= key[j-1];
          end
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.emit_kind)
        scpf_pkg::EMIT_PAST: begin
          scanline   <= line_r;
          span_start <= '0;
          span_end   <= '0;
          span_valid <= 1'b0;
          last       <= 1'b1;
          fill_done  <= 1'b1;
          table_full <= 1'b0;
        end
        scpf_pkg::EMIT_SPAN: begin
          scanline   <= line_r;
          span_start <= few_edges ? '0 : pix_lo;
          span_end   <= few_edges ? '0 : pix_hi;
          span_valid <= !few_edges;
          last       <= few_edges || span_last;
          fill_done  <= current_line >= top_y;
          table_full <= 1'b0;
        end
        default: begin
          scanline   <= '0;
          span_start <= '0;
          span_end   <= '0;
          span_valid <= 1'b0;
          last       <= 1'b1;
          fill_done  <= 1'b0;
          table_full <= full_flag;
        end
      endcase
    end
  end

endmodule

/* rtl/scpf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpf_ctrl
// Controller state machine: sequences edge storage, vertex update, clear, scanline
// scan and span emission over the datapath.
// ----------------------------------------------------------------------------
module scpf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         command,
  input  scpf_pkg::dp_stat_t stat,
  output scpf_pkg::dp_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_E_SETUP,
    S_E_DIV,
    S_E_WRITE,
    S_V_UPD,
    S_CLEAR,
    S_ACK,
    S_F_CHECK,
    S_F_SCAN,
    S_F_LINE,
    S_F_EMIT
  } state_t;

  state_t state, state_next;
  logic   second, second_next;

  assign busy = (state != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next    = state;
    second_next   = second;
    cmd           = '0;
    cmd.edge_sel  = second ? scpf_pkg::SEL_NEW_TO_FIRST : scpf_pkg::SEL_PREV_TO_NEW;
    cmd.emit_kind = scpf_pkg::EMIT_ACK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch   = 1'b1;
          second_next = 1'b0;
          priority case (command)
            scpf_pkg::CMD_CLEAR: state_next = S_CLEAR;
            scpf_pkg::CMD_FILL:  state_next = S_F_CHECK;
            default:             state_next = stat.vertex_seen ? S_E_SETUP : S_V_UPD;
          endcase
        end
      end
      S_E_SETUP: begin
        if (!stat.horiz && !stat.full) begin
          cmd.div_start = 1'b1;
          state_next    = S_E_DIV;
        end else begin
          cmd.set_full = !stat.horiz;
          state_next   = second ? S_ACK : S_V_UPD;
        end
      end
      S_E_DIV: begin
        if (!stat.div_busy) begin
          state_next = S_E_WRITE;
        end
      end
      S_E_WRITE: begin
        cmd.edge_write = 1'b1;
        state_next     = second ? S_ACK : S_V_UPD;
      end
      S_V_UPD: begin
        cmd.vtx_update = 1'b1;
        if (stat.close_cmd) begin
          second_next = 1'b1;
          state_next  = S_E_SETUP;
        end else begin
          state_next = S_ACK;
        end
      end
      S_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = S_ACK;
      end
      S_ACK: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      S_F_CHECK: begin
        if (stat.past_top) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = scpf_pkg::EMIT_PAST;
          state_next    = S_IDLE;
        end else if (stat.no_edges) begin
          state_next = S_F_LINE;
        end else begin
          state_next = S_F_SCAN;
        end
      end
      S_F_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_F_LINE;
        end
      end
      S_F_LINE: begin
        cmd.line_adv = 1'b1;
        state_next   = S_F_EMIT;
      end
      S_F_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = scpf_pkg::EMIT_SPAN;
        if (stat.emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

endmodule

/* rtl/scanline_polygon_span_fill_unit.sv */
`timescale 1ns / 1ps
// Steps from transfer to result: a vertex stores an edge (setup, slope division, write)
//   when it has one, then updates the vertex state and acknowledges; close adds the closing edge.
// Fill: past the top, a single result; else every stored edge is scanned, the line advances,
//   then one span per cycle, up to 16; clear empties the store; one command at a time.
// Reset: synchronous active high; empties the edge store and vertex state.
// Results come one per cycle on result_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
// scanline_polygon_span_fill_unit
// Top level: polygon edge store with active edge sort and span generation.
// ----------------------------------------------------------------------------
module scanline_polygon_span_fill_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command,
  input  logic [scpf_pkg::COORD_W-1:0] vertex_x,
  input  logic [scpf_pkg::COORD_W-1:0] vertex_y,
  output logic                         result_valid,
  output logic [scpf_pkg::COORD_W-1:0] scanline,
  output logic [scpf_pkg::COORD_W-1:0] span_start,
  output logic [scpf_pkg::COORD_W-1:0] span_end,
  output logic                         span_valid,
  output logic                         last,
  output logic                         fill_done,
  output logic                         table_full
);

  scpf_pkg::dp_cmd_t  dp_cmd;
  scpf_pkg::dp_stat_t dp_stat;

  scpf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (dp_stat),
    .cmd     (dp_cmd),
    .busy    (busy)
  );

  scpf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .command      (command),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .result_valid (result_valid),
    .scanline     (scanline),
    .span_start   (span_start),
    .span_end     (span_end),
    .span_valid   (span_valid),
    .last         (last),
    .fill_done    (fill_done),
    .table_full   (table_full)
  );

endmodule

/* rtl/scpf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpf_checker
// Port-level checks of the span fill unit, bound to the top level.
// ----------------------------------------------------------------------------
module scpf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         result_valid,
  input logic [scpf_pkg::COORD_W-1:0] span_start,
  input logic [scpf_pkg::COORD_W-1:0] span_end,
  input logic                         span_valid,
  input logic                         last,
  input logic                         table_full
);

  // an accepted command keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after transfer");

  // a result without a span ends its command
  a_nospan_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !span_valid |-> last) else $error("empty result not last");

  // spans come from x-sorted edges
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && span_valid |-> span_start <= span_end)
    else $error("span ends out of order");

  // table full only on vertex acknowledges
  a_full_ack: assert property (@(posedge clk) disable iff (rst)
    result_valid && table_full |-> last && !span_valid)
    else $error("table_full on a span result");

endmodule

bind scanline_polygon_span_fill_unit scpf_checker u_scpf_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .span_start   (span_start),
  .span_end     (span_end),
  .span_valid   (span_valid),
  .last         (last),
  .table_full   (table_full)
);
